[rtl/core/fsp_pkg.sv]
// shared types and constants for the format specification parser
// holds the phase encoding, parser state, result record and character codes
// no dependencies
`timescale 1ns / 1ps

package fsp_pkg;

	// largest value a width or precision can hold
	localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

	// characters the parser acts on
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LC_C  = 8'h63;
	localparam logic [7:0] CH_LC_S  = 8'h73;
	localparam logic [7:0] CH_LC_P  = 8'h70;
	localparam logic [7:0] CH_LC_D  = 8'h64;
	localparam logic [7:0] CH_LC_I  = 8'h69;
	localparam logic [7:0] CH_LC_U  = 8'h75;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_PCT   = 8'h25;

	// conversion codes on the result
	typedef enum logic [3:0] {
		CV_CHAR    = 4'd0,
		CV_STRING  = 4'd1,
		CV_POINTER = 4'd2,
		CV_DEC     = 4'd3,
		CV_INT     = 4'd4,
		CV_UNSIGND = 4'd5,
		CV_HEX_LO  = 4'd6,
		CV_HEX_UP  = 4'd7,
		CV_PERCENT = 4'd8
	} conv_t;

	// parse phases, one-hot
	typedef enum logic [5:0] {
		PH_FLAGS     = 6'b000001,
		PH_WIDTH     = 6'b000010,
		PH_AFT_WIDTH = 6'b000100,
		PH_AFT_DOT   = 6'b001000,
		PH_PREC      = 6'b010000,
		PH_AFT_STAR  = 6'b100000
	} phase_t;

	// flag bit positions
	localparam int unsigned FL_LEFT  = 0;
	localparam int unsigned FL_ZERO  = 1;
	localparam int unsigned FL_PLUS  = 2;
	localparam int unsigned FL_SPACE = 3;
	localparam int unsigned FL_ALT   = 4;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  flags;
		logic [30:0] width;
		logic        prec_given;
		logic [30:0] prec;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:      PH_FLAGS,
		flags:      5'd0,
		width:      31'd0,
		prec_given: 1'b0,
		prec:       31'd0
	};

	typedef struct packed {
		logic        left_align;
		logic        zero_pad;
		logic        force_plus;
		logic        space_sign;
		logic        alternate_form;
		logic [30:0] field_width;
		logic        precision_given;
		logic [30:0] precision_value;
		logic [3:0]  conversion;
		logic        valid_res;
		logic        char_consumed;
	} result_t;

endpackage

[rtl/core/format_spec_parser.sv]
// top level of the format specification parser: input register, parser state,
// result register; uses fsp_pkg and fsp_step
//
//   channel | handshake                  | payload
//   item    | item_valid / item_stall    | character, star_argument
//   result  | result_valid / result_stall| flags, field_width, precision_*, conversion, status
//
// one character per cycle unless item_stall holds it; the character ending the specification
// passes the input register, then its result is captured in the result register
// the parser state is updated as each character leaves the input register
// a held result stalls only a character that would produce another result
// reset clears the phase, flags, accumulators and both valid bits
`timescale 1ns / 1ps

module format_spec_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [7:0]         character,
	input  logic signed [31:0] star_argument,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               left_align,
	output logic               zero_pad,
	output logic               force_plus,
	output logic               space_sign,
	output logic               alternate_form,
	output logic [30:0]        field_width,
	output logic               precision_given,
	output logic [30:0]        precision_value,
	output logic [3:0]         conversion,
	output logic               valid_res,
	output logic               char_consumed
);

	logic             vld_s1;
	logic [7:0]       chr_s1;
	logic [31:0]      arg_s1;
	fsp_pkg::state_t  state_q;
	fsp_pkg::state_t  state_nxt;
	logic             emit;
	fsp_pkg::result_t res;
	fsp_pkg::result_t res_q;
	logic             res_vld_q;
	logic             out_free;
	logic             advance;
	logic             accept;

	// handshake control
	assign out_free   = !res_vld_q || !result_stall;
	assign advance    = vld_s1 && (!emit || out_free);
	assign item_stall = vld_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	fsp_step u_step (
		.st            (state_q),
		.character     (chr_s1),
		.star_argument (arg_s1),
		.nxt           (state_nxt),
		.emit          (emit),
		.res           (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chr_s1 <= character;
			arg_s1 <= star_argument;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsp_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance && emit) begin
			res_vld_q <= 1'b1;
		end else if (!result_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	// outputs
	assign result_valid    = res_vld_q;
	assign left_align      = res_q.left_align;
	assign zero_pad        = res_q.zero_pad;
	assign force_plus      = res_q.force_plus;
	assign space_sign      = res_q.space_sign;
	assign alternate_form  = res_q.alternate_form;
	assign field_width     = res_q.field_width;
	assign precision_given = res_q.precision_given;
	assign precision_value = res_q.precision_value;
	assign conversion      = res_q.conversion;
	assign valid_res       = res_q.valid_res;
	assign char_consumed   = res_q.char_consumed;

endmodule

[rtl/core/fsp_step.sv]
// next-state and result logic for one character of a specification
// combinational; uses fsp_pkg for the state, result and character codes
`timescale 1ns / 1ps

module fsp_step (
	input  fsp_pkg::state_t  st,
	input  logic [7:0]       character,
	input  logic [31:0]      star_argument,
	output fsp_pkg::state_t  nxt,
	output logic             emit,
	output fsp_pkg::result_t res
);

	// append one decimal digit, saturating
	function automatic logic [30:0] add_digit(input logic [30:0] acc, input logic [3:0] d);
		logic [34:0] sum;
		sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
		if (sum > {4'd0, fsp_pkg::SAT_MAX})
			return fsp_pkg::SAT_MAX;
		return sum[30:0];
	endfunction

	logic        is_digit;
	logic [3:0]  dval;
	logic        neg;
	logic [31:0] mag_full;
	logic [30:0] mag;
	fsp_pkg::phase_t eff;
	logic        done;
	logic        known;
	fsp_pkg::conv_t conv;

	// character classes and the starred magnitude
	assign is_digit = (character >= fsp_pkg::CH_ZERO) && (character <= fsp_pkg::CH_NINE);
	assign dval     = character[3:0];
	assign neg      = star_argument[31];
	assign mag_full = neg ? (32'd0 - star_argument) : star_argument;
	assign mag      = mag_full[31] ? fsp_pkg::SAT_MAX : mag_full[30:0];

	// specifier lookup
	always_comb begin
		known = 1'b1;
		conv  = fsp_pkg::CV_CHAR;
		case (character)
			fsp_pkg::CH_LC_C: conv = fsp_pkg::CV_CHAR;
			fsp_pkg::CH_LC_S: conv = fsp_pkg::CV_STRING;
			fsp_pkg::CH_LC_P: conv = fsp_pkg::CV_POINTER;
			fsp_pkg::CH_LC_D: conv = fsp_pkg::CV_DEC;
			fsp_pkg::CH_LC_I: conv = fsp_pkg::CV_INT;
			fsp_pkg::CH_LC_U: conv = fsp_pkg::CV_UNSIGND;
			fsp_pkg::CH_LC_X: conv = fsp_pkg::CV_HEX_LO;
			fsp_pkg::CH_UC_X: conv = fsp_pkg::CV_HEX_UP;
			fsp_pkg::CH_PCT:  conv = fsp_pkg::CV_PERCENT;
			default:          known = 1'b0;
		endcase
	end

	// result record, built from the state before this character
	always_comb begin
		res.left_align      = st.flags[fsp_pkg::FL_LEFT];
		res.zero_pad        = st.flags[fsp_pkg::FL_ZERO];
		res.force_plus      = st.flags[fsp_pkg::FL_PLUS];
		res.space_sign      = st.flags[fsp_pkg::FL_SPACE];
		res.alternate_form  = st.flags[fsp_pkg::FL_ALT];
		res.field_width     = st.width;
		res.precision_given = st.prec_given;
		res.precision_value = st.prec_given ? st.prec : 31'd0;
		res.conversion      = known ? conv : fsp_pkg::CV_CHAR;
		res.valid_res       = known;
		res.char_consumed   = known;
	end

	// phase walk; flags and width phases may fall through to the later ones
	always_comb begin
		nxt  = st;
		done = 1'b0;
		eff  = st.phase;
		case (st.phase)
			fsp_pkg::PH_FLAGS: begin
				done = 1'b1;
				if (character == fsp_pkg::CH_MINUS)
					nxt.flags[fsp_pkg::FL_LEFT] = 1'b1;
				else if (character == fsp_pkg::CH_ZERO)
					nxt.flags[fsp_pkg::FL_ZERO] = 1'b1;
				else if (character == fsp_pkg::CH_PLUS)
					nxt.flags[fsp_pkg::FL_PLUS] = 1'b1;
				else if (character == fsp_pkg::CH_SPACE)
					nxt.flags[fsp_pkg::FL_SPACE] = 1'b1;
				else if (character == fsp_pkg::CH_HASH)
					nxt.flags[fsp_pkg::FL_ALT] = 1'b1;
				else if (character == fsp_pkg::CH_STAR) begin
					if (neg)
						nxt.flags[fsp_pkg::FL_LEFT] = 1'b1;
					nxt.width = mag;
					nxt.phase = fsp_pkg::PH_AFT_WIDTH;
				end else if (is_digit) begin
					nxt.width = add_digit(st.width, dval);
					nxt.phase = fsp_pkg::PH_WIDTH;
				end else begin
					done = 1'b0;
					eff  = fsp_pkg::PH_AFT_WIDTH;
				end
			end
			fsp_pkg::PH_WIDTH: begin
				if (is_digit) begin
					nxt.width = add_digit(st.width, dval);
					done      = 1'b1;
				end else begin
					eff = fsp_pkg::PH_AFT_WIDTH;
				end
			end
			default: ;
		endcase

		if (!done) begin
			case (eff)
				fsp_pkg::PH_AFT_WIDTH: begin
					if (character == fsp_pkg::CH_DOT) begin
						nxt.prec_given = 1'b1;
						nxt.prec       = 31'd0;
						nxt.phase      = fsp_pkg::PH_AFT_DOT;
						done           = 1'b1;
					end
				end
				fsp_pkg::PH_AFT_DOT: begin
					if (character == fsp_pkg::CH_STAR) begin
						if (neg) begin
							nxt.prec_given = 1'b0;
							nxt.prec       = 31'd0;
						end else begin
							nxt.prec = mag;
						end
						nxt.phase = fsp_pkg::PH_AFT_STAR;
						done      = 1'b1;
					end else if (is_digit) begin
						nxt.prec  = add_digit(st.prec, dval);
						nxt.phase = fsp_pkg::PH_PREC;
						done      = 1'b1;
					end
				end
				fsp_pkg::PH_PREC: begin
					if (is_digit) begin
						nxt.prec = add_digit(st.prec, dval);
						done     = 1'b1;
					end
				end
				default: ;
			endcase
		end

		// end of specification: report and start over
		emit = !done;
		if (!done)
			nxt = fsp_pkg::STATE_RESET;
	end

endmodule

[dv/tb_top.sv]
// testbench for format_spec_parser: random and directed format characters
// with a scoreboard that predicts each parsed specification; uses fsp_pkg
`timescale 1ns / 1ps

module tb_top;

	// cycles with no transaction on either channel before the run is abandoned
	localparam int unsigned STALL_LIMIT = 5000;
	// random characters after the directed part
	localparam int unsigned RANDOM_CHARS = 400;
	// cycles allowed after the last expected result
	localparam int unsigned DRAIN_CYCLES = 10;

	// spec predictor and store of pending specifications
	class spec_scoreboard;
		fsp_pkg::phase_t  phase;
		logic [4:0]       flags;
		logic [30:0]      width;
		logic             prec_given;
		logic [30:0]      prec;
		fsp_pkg::result_t pending_specs[$];
		int unsigned      errors;

		function new();
			clear_spec();
			errors = 0;
		endfunction

		function void clear_spec();
			phase      = fsp_pkg::PH_FLAGS;
			flags      = 5'd0;
			width      = 31'd0;
			prec_given = 1'b0;
			prec       = 31'd0;
		endfunction

		static function logic is_digit(logic [7:0] c);
			return c >= fsp_pkg::CH_ZERO && c <= fsp_pkg::CH_NINE;
		endfunction

		// append one decimal digit, saturating
		static function logic [30:0] sat_digit(logic [30:0] acc, logic [7:0] c);
			logic [31:0] d;
			logic [31:0] lim;
			d   = {24'd0, c - fsp_pkg::CH_ZERO};
			lim = ({1'b0, fsp_pkg::SAT_MAX} - d) / 32'd10;
			if ({1'b0, acc} > lim)
				return fsp_pkg::SAT_MAX;
			return 31'(acc * 31'd10 + d[30:0]);
		endfunction

		// predict the effect of one accepted character
		function void note_char(logic [7:0] c, logic signed [31:0] arg);
			logic [31:0]      mag;
			logic             neg;
			logic             ended;
			logic             known;
			fsp_pkg::conv_t   code;
			fsp_pkg::result_t res;
			neg = arg[31];
			mag = neg ? (32'd0 - arg) : arg;
			if (mag > {1'b0, fsp_pkg::SAT_MAX})
				mag = {1'b0, fsp_pkg::SAT_MAX};
			ended = 1'b1;

			// flags and width
			if (phase == fsp_pkg::PH_FLAGS) begin
				ended = 1'b0;
				case (c)
					fsp_pkg::CH_MINUS: flags[fsp_pkg::FL_LEFT]  = 1'b1;
					fsp_pkg::CH_ZERO:  flags[fsp_pkg::FL_ZERO]  = 1'b1;
					fsp_pkg::CH_PLUS:  flags[fsp_pkg::FL_PLUS]  = 1'b1;
					fsp_pkg::CH_SPACE: flags[fsp_pkg::FL_SPACE] = 1'b1;
					fsp_pkg::CH_HASH:  flags[fsp_pkg::FL_ALT]   = 1'b1;
					fsp_pkg::CH_STAR: begin
						if (neg)
							flags[fsp_pkg::FL_LEFT] = 1'b1;
						width = mag[30:0];
						phase = fsp_pkg::PH_AFT_WIDTH;
					end
					default: begin
						if (is_digit(c)) begin
							width = sat_digit(width, c);
							phase = fsp_pkg::PH_WIDTH;
						end else begin
							phase = fsp_pkg::PH_AFT_WIDTH;
							ended = 1'b1;
						end
					end
				endcase
			end else if (phase == fsp_pkg::PH_WIDTH) begin
				if (is_digit(c)) begin
					width = sat_digit(width, c);
					ended = 1'b0;
				end else begin
					phase = fsp_pkg::PH_AFT_WIDTH;
				end
			end

			// dot and precision
			if (ended) begin
				case (phase)
					fsp_pkg::PH_AFT_WIDTH: begin
						if (c == fsp_pkg::CH_DOT) begin
							prec_given = 1'b1;
							prec       = 31'd0;
							phase      = fsp_pkg::PH_AFT_DOT;
							ended      = 1'b0;
						end
					end
					fsp_pkg::PH_AFT_DOT: begin
						if (c == fsp_pkg::CH_STAR) begin
							if (neg) begin
								prec_given = 1'b0;
								prec       = 31'd0;
							end else begin
								prec = mag[30:0];
							end
							phase = fsp_pkg::PH_AFT_STAR;
							ended = 1'b0;
						end else if (is_digit(c)) begin
							prec  = sat_digit(prec, c);
							phase = fsp_pkg::PH_PREC;
							ended = 1'b0;
						end
					end
					fsp_pkg::PH_PREC: begin
						if (is_digit(c)) begin
							prec  = sat_digit(prec, c);
							ended = 1'b0;
						end
					end
					default: ;
				endcase
			end

			// specifier or unexpected character closes the specification
			if (ended) begin
				known = 1'b1;
				code  = fsp_pkg::CV_CHAR;
				case (c)
					fsp_pkg::CH_LC_C: code = fsp_pkg::CV_CHAR;
					fsp_pkg::CH_LC_S: code = fsp_pkg::CV_STRING;
					fsp_pkg::CH_LC_P: code = fsp_pkg::CV_POINTER;
					fsp_pkg::CH_LC_D: code = fsp_pkg::CV_DEC;
					fsp_pkg::CH_LC_I: code = fsp_pkg::CV_INT;
					fsp_pkg::CH_LC_U: code = fsp_pkg::CV_UNSIGND;
					fsp_pkg::CH_LC_X: code = fsp_pkg::CV_HEX_LO;
					fsp_pkg::CH_UC_X: code = fsp_pkg::CV_HEX_UP;
					fsp_pkg::CH_PCT:  code = fsp_pkg::CV_PERCENT;
					default:          known = 1'b0;
				endcase
				res.left_align      = flags[fsp_pkg::FL_LEFT];
				res.zero_pad        = flags[fsp_pkg::FL_ZERO];
				res.force_plus      = flags[fsp_pkg::FL_PLUS];
				res.space_sign      = flags[fsp_pkg::FL_SPACE];
				res.alternate_form  = flags[fsp_pkg::FL_ALT];
				res.field_width     = width;
				res.precision_given = prec_given;
				res.precision_value = prec_given ? prec : 31'd0;
				res.conversion      = known ? code : fsp_pkg::CV_CHAR;
				res.valid_res       = known;
				res.char_consumed   = known;
				pending_specs.push_back(res);
				clear_spec();
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(fsp_pkg::result_t got);
			fsp_pkg::result_t want;
			if (pending_specs.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, got);
				errors++;
				return;
			end
			want = pending_specs.pop_front();
			compare_field("left_align", want.left_align, got.left_align);
			compare_field("zero_pad", want.zero_pad, got.zero_pad);
			compare_field("force_plus", want.force_plus, got.force_plus);
			compare_field("space_sign", want.space_sign, got.space_sign);
			compare_field("alternate_form", want.alternate_form, got.alternate_form);
			compare_field("field_width", want.field_width, got.field_width);
			compare_field("precision_given", want.precision_given, got.precision_given);
			compare_field("precision_value", want.precision_value, got.precision_value);
			compare_field("conversion", want.conversion, got.conversion);
			compare_field("valid_res", want.valid_res, got.valid_res);
			compare_field("char_consumed", want.char_consumed, got.char_consumed);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [7:0]         character = 8'd0;
	logic signed [31:0] star_argument = 32'sd0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               left_align;
	logic               zero_pad;
	logic               force_plus;
	logic               space_sign;
	logic               alternate_form;
	logic [30:0]        field_width;
	logic               precision_given;
	logic [30:0]        precision_value;
	logic [3:0]         conversion;
	logic               valid_res;
	logic               char_consumed;

	spec_scoreboard sb = new();
	int unsigned    send_idle_pct = 9;
	int unsigned    recv_idle_pct = 73;
	int unsigned    chars_sent = 0;
	int unsigned    quiet_cycles = 0;

	logic [7:0] flag_chars [5] = '{fsp_pkg::CH_MINUS, fsp_pkg::CH_ZERO, fsp_pkg::CH_PLUS,
		fsp_pkg::CH_SPACE, fsp_pkg::CH_HASH};
	logic [7:0] conv_chars [9] = '{fsp_pkg::CH_LC_C, fsp_pkg::CH_LC_S, fsp_pkg::CH_LC_P,
		fsp_pkg::CH_LC_D, fsp_pkg::CH_LC_I, fsp_pkg::CH_LC_U, fsp_pkg::CH_LC_X,
		fsp_pkg::CH_UC_X, fsp_pkg::CH_PCT};

	format_spec_parser i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.character       (character),
		.star_argument   (star_argument),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.left_align      (left_align),
		.zero_pad        (zero_pad),
		.force_plus      (force_plus),
		.space_sign      (space_sign),
		.alternate_form  (alternate_form),
		.field_width     (field_width),
		.precision_given (precision_given),
		.precision_value (precision_value),
		.conversion      (conversion),
		.valid_res       (valid_res),
		.char_consumed   (char_consumed)
	);

	always #5 clk = ~clk;

	// result side: check accepted transactions, then pick the next stall
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			sb.check_result(fsp_pkg::result_t'{
				left_align:      left_align,
				zero_pad:        zero_pad,
				force_plus:      force_plus,
				space_sign:      space_sign,
				alternate_form:  alternate_form,
				field_width:     field_width,
				precision_given: precision_given,
				precision_value: precision_value,
				conversion:      conversion,
				valid_res:       valid_res,
				char_consumed:   char_consumed
			});
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// star argument biased toward the extremes
	function automatic logic signed [31:0] rand_star();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return -32'sd1;
			3: return 32'sd0;
			4, 5: return $signed($urandom_range(200)) - 32'sd100;
			default: return $urandom;
		endcase
	endfunction

	// present one character and wait until it is taken
	task automatic send_char(input logic [7:0] c, input logic signed [31:0] arg);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid    <= 1'b1;
		character     <= c;
		star_argument <= arg;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_char(c, arg);
		chars_sent++;
	endtask

	// decimal run, occasionally long enough to saturate
	task automatic send_digits(input logic lead_nonzero);
		int unsigned len;
		len = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
		send_char(lead_nonzero ? fsp_pkg::CH_ZERO + 8'($urandom_range(1, 9))
			: fsp_pkg::CH_ZERO + 8'($urandom_range(9)), $urandom);
		repeat (len - 1)
			send_char(fsp_pkg::CH_ZERO + 8'($urandom_range(9)), $urandom);
	endtask

	// well-formed specification with random content, sometimes a bad ending
	task automatic send_spec();
		int unsigned n_flags;
		n_flags = $urandom_range(3);
		repeat (n_flags)
			send_char(flag_chars[$urandom_range(4)], $urandom);
		case ($urandom_range(3))
			0: ;
			1: send_char(fsp_pkg::CH_STAR, rand_star());
			default: send_digits(1'b1);
		endcase
		case ($urandom_range(3))
			0: ;
			1: send_char(fsp_pkg::CH_DOT, $urandom);
			2: begin
				send_char(fsp_pkg::CH_DOT, $urandom);
				send_char(fsp_pkg::CH_STAR, rand_star());
			end
			default: begin
				send_char(fsp_pkg::CH_DOT, $urandom);
				send_digits(1'b0);
			end
		endcase
		if ($urandom_range(9) == 0)
			send_char(8'($urandom_range(255)), rand_star());
		else
			send_char(conv_chars[$urandom_range(8)], $urandom);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every flag, zero taken as a flag, short width, dot without digits
		send_char(fsp_pkg::CH_MINUS, $urandom);
		send_char(fsp_pkg::CH_ZERO, $urandom);
		send_char(fsp_pkg::CH_PLUS, $urandom);
		send_char(fsp_pkg::CH_SPACE, $urandom);
		send_char(fsp_pkg::CH_HASH, $urandom);
		send_char(fsp_pkg::CH_ZERO + 8'd1, $urandom);
		send_char(fsp_pkg::CH_DOT, $urandom);
		send_char(fsp_pkg::CH_LC_D, $urandom);
		// most negative starred width, negative starred precision
		send_char(fsp_pkg::CH_STAR, 32'sh8000_0000);
		send_char(fsp_pkg::CH_DOT, $urandom);
		send_char(fsp_pkg::CH_STAR, -32'sd1);
		send_char(fsp_pkg::CH_LC_X, $urandom);
		// largest starred width and precision
		send_char(fsp_pkg::CH_STAR, 32'sh7FFF_FFFF);
		send_char(fsp_pkg::CH_DOT, $urandom);
		send_char(fsp_pkg::CH_STAR, 32'sh7FFF_FFFF);
		send_char(fsp_pkg::CH_UC_X, $urandom);
		// small negative starred width
		send_char(fsp_pkg::CH_STAR, -32'sd5);
		send_char(fsp_pkg::CH_LC_C, $urandom);
		// nul and all-ones bytes end the specification unconsumed
		send_char(8'h00, 32'sd0);
		send_char(fsp_pkg::CH_ZERO + 8'd5, $urandom);
		send_char(8'hFF, 32'shFFFF_FFFF);
		send_char(fsp_pkg::CH_PCT, $urandom);

		// random part in three idling phases
		chars_sent = 0;
		while (chars_sent < RANDOM_CHARS) begin
			if (chars_sent >= 2 * RANDOM_CHARS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (chars_sent >= RANDOM_CHARS / 3) begin
				send_idle_pct = 73;
				recv_idle_pct = 9;
			end
			if ($urandom_range(99) < 80) begin
				send_spec();
			end else begin
				repeat ($urandom_range(1, 4))
					send_char(8'($urandom_range(255)), rand_star());
			end
		end
		item_valid <= 1'b0;

		// drain outstanding results
		while (sb.pending_specs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_specs.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/core/fsp_pkg.sv
rtl/core/fsp_step.sv
rtl/core/format_spec_parser.sv
dv/tb_top.sv
